// ----- sv/bpd_pkg.sv -----
// bpd_pkg: shared types, sizes and decode functions for the byte-level BPE piece decoder.
// No dependencies; used by every module of the block.
package bpd_pkg;

	// Longest UTF-8 sequence, and so the most bytes and results one group can hold
	localparam int GrpBytes = 4;

	// Group queue between the front and the back
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// One finished group of input bytes: a whole sequence, or whatever a piece end cut off
	typedef struct packed {
		logic [GrpBytes-1:0][7:0] bytes;
		logic [2:0]               total;
	} grp_t;

	// Results of one group, already compacted: slots 0..last_idx are valid
	typedef struct packed {
		logic [GrpBytes-1:0][7:0] res_byte;
		logic [GrpBytes-1:0]      res_raw;
		logic [1:0]               last_idx;
	} entry_t;

	// Front status, watched by the top level checks
	typedef struct packed {
		logic       s1_valid;
		logic [1:0] pend_cnt;
	} fstat_t;

	// Sequence length announced by a lead byte; a bad lead counts as one byte
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		begin
			if (b[7] == 1'b0)
				n = 3'd1;
			else if ((b & 8'hE0) == 8'hC0)
				n = 3'd2;
			else if ((b & 8'hF0) == 8'hE0)
				n = 3'd3;
			else if ((b & 8'hF8) == 8'hF0)
				n = 3'd4;
			else
				n = 3'd1;
			return n;
		end
	endfunction

	// Inverse byte-to-unicode table over code points below 512.
	// Returns {hit, byte}.
	function automatic logic [8:0] inv_map(input logic [8:0] cp);
		logic [7:0] lo;
		logic [8:0] r;
		begin
			lo = cp[7:0];
			r  = 9'd0;
			if (cp[8] == 1'b0) begin
				if ((lo >= 8'd33 && lo <= 8'd126) || (lo >= 8'd161 && lo <= 8'd172) ||
				    (lo >= 8'd174))
					r = {1'b1, lo};
			end else begin
				if (lo < 8'd33)
					r = {1'b1, lo};
				else if (lo < 8'd67)
					r = {1'b1, lo + 8'd94};
				else if (lo == 8'd67)
					r = {1'b1, 8'd173};
			end
			return r;
		end
	endfunction

endpackage

// ----- sv/bpd_front.sv -----
// bpd_front: accepts bytes, collects UTF-8 sequences and turns each finished group
// into a compacted list of results. Depends on bpd_pkg.
module bpd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             piece_end,
	output logic             push,
	output bpd_pkg::entry_t  push_entry,
	input  logic             q_ready,
	output bpd_pkg::fstat_t  fstat
);

	logic [1:0]      cnt_q;
	logic [2:0]      expect_q;
	logic [7:0]      pend_q [0:2];
	bpd_pkg::grp_t   grp_s1;
	logic            valid_s1;

	logic            in_acc;
	logic [2:0]      exp_len;
	logic [2:0]      total;
	logic            complete;
	bpd_pkg::grp_t   grp_next;

	assign push     = valid_s1 && q_ready;
	assign in_ready = !valid_s1 || push;
	assign in_acc   = in_valid && in_ready;

	assign exp_len  = (cnt_q == 2'd0) ? bpd_pkg::lead_len(in_byte) : expect_q;
	assign total    = {1'b0, cnt_q} + 3'd1;
	assign complete = piece_end || (total >= exp_len) || (total == 3'd4);

	always_comb begin
		grp_next.bytes[0] = (cnt_q == 2'd0) ? in_byte : pend_q[0];
		grp_next.bytes[1] = (cnt_q == 2'd1) ? in_byte : pend_q[1];
		grp_next.bytes[2] = (cnt_q == 2'd2) ? in_byte : pend_q[2];
		grp_next.bytes[3] = in_byte;
		grp_next.total    = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			expect_q <= 3'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				if (complete) begin
					cnt_q    <= 2'd0;
					expect_q <= 3'd0;
				end else begin
					cnt_q    <= total[1:0];
					expect_q <= exp_len;
				end
			end
			if (in_acc && complete)
				valid_s1 <= 1'b1;
			else if (push)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && complete)
			grp_s1 <= grp_next;
		if (in_acc && !complete) begin
			case (cnt_q)
				2'd0:    pend_q[0] <= in_byte;
				2'd1:    pend_q[1] <= in_byte;
				2'd2:    pend_q[2] <= in_byte;
				default: ;
			endcase
		end
	end

	// Classify the held group: decode at every start position in parallel,
	// then walk the real leads and compact the results.
	logic [6:0][7:0]                  ext;
	logic [bpd_pkg::GrpBytes-1:0][2:0] n_eff;
	logic [bpd_pkg::GrpBytes-1:0]      hit;
	logic [bpd_pkg::GrpBytes-1:0][7:0] mapb;

	assign ext = {24'd0, grp_s1.bytes};

	always_comb begin
		logic [7:0] b0, b1, b2, b3;
		logic [2:0] n;
		logic       fits9;
		logic [8:0] cp;
		logic [8:0] lk;
		n_eff = '0;
		hit   = '0;
		mapb  = '0;
		for (int p = 0; p < bpd_pkg::GrpBytes; p++) begin
			b0 = ext[p];
			b1 = ext[p + 1];
			b2 = ext[p + 2];
			b3 = ext[p + 3];
			n  = bpd_pkg::lead_len(b0);
			// sequence runs past the group end: lead stands alone
			if ((4'(p) + {1'b0, n}) > {1'b0, grp_s1.total})
				n = 3'd1;
			case (n)
				3'd2: begin
					fits9 = (b0[4:3] == 2'd0);
					cp    = {b0[2:0], b1[5:0]};
				end
				3'd3: begin
					fits9 = (b0[3:0] == 4'd0) && (b1[5:3] == 3'd0);
					cp    = {b1[2:0], b2[5:0]};
				end
				3'd4: begin
					fits9 = (b0[2:0] == 3'd0) && (b1[5:0] == 6'd0) && (b2[5:3] == 3'd0);
					cp    = {b2[2:0], b3[5:0]};
				end
				default: begin
					fits9 = 1'b1;
					cp    = {1'b0, b0};
				end
			endcase
			lk       = bpd_pkg::inv_map(cp);
			hit[p]   = fits9 && lk[8];
			mapb[p]  = lk[7:0];
			n_eff[p] = n;
		end
	end

	always_comb begin
		logic [2:0]                        pos;
		logic [1:0]                        lead;
		logic [bpd_pkg::GrpBytes-1:0]      v;
		logic [bpd_pkg::GrpBytes-1:0][7:0] rb;
		logic [bpd_pkg::GrpBytes-1:0]      rr;
		logic [2:0]                        k;
		pos        = 3'd0;
		lead       = 2'd0;
		v          = '0;
		rb         = '0;
		rr         = '0;
		k          = 3'd0;
		push_entry = '0;
		for (int step = 0; step < bpd_pkg::GrpBytes; step++) begin
			if (pos < grp_s1.total) begin
				lead = pos[1:0];
				for (int j = 0; j < bpd_pkg::GrpBytes; j++) begin
					if ((3'(j) >= pos) && (4'(j) < ({1'b0, pos} + {1'b0, n_eff[lead]}))) begin
						if (hit[lead]) begin
							if (3'(j) == pos) begin
								v[j]  = 1'b1;
								rb[j] = mapb[lead];
								rr[j] = 1'b0;
							end
						end else begin
							v[j]  = 1'b1;
							rb[j] = grp_s1.bytes[j];
							rr[j] = 1'b1;
						end
					end
				end
				pos = pos + n_eff[lead];
			end
		end
		for (int j = 0; j < bpd_pkg::GrpBytes; j++) begin
			if (v[j]) begin
				push_entry.res_byte[k[1:0]] = rb[j];
				push_entry.res_raw[k[1:0]]  = rr[j];
				k = k + 3'd1;
			end
		end
		push_entry.last_idx = k[1:0] - 2'd1;
	end

	assign fstat.s1_valid = valid_s1;
	assign fstat.pend_cnt = cnt_q;

endmodule

// ----- sv/bpd_queue.sv -----
// bpd_queue: small FIFO of result groups between the front and the back.
// Depends on bpd_pkg.
module bpd_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bpd_pkg::entry_t            push_entry,
	output logic                       q_ready,
	input  logic                       pop,
	output bpd_pkg::entry_t            head,
	output logic                       head_valid,
	output logic [bpd_pkg::QCntW-1:0]  level
);

	bpd_pkg::entry_t                 ent_q [0:bpd_pkg::QDepth-1];
	logic [bpd_pkg::QPtrW-1:0]       wr_ptr_q;
	logic [bpd_pkg::QPtrW-1:0]       rd_ptr_q;
	logic [bpd_pkg::QCntW-1:0]       cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign q_ready    = (cnt_q != bpd_pkg::QCntW'(bpd_pkg::QDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_ptr_q];
	assign level      = cnt_q;
	assign do_push    = push && q_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == bpd_pkg::QPtrW'(bpd_pkg::QDepth - 1)) ? '0 :
				            wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == bpd_pkg::QPtrW'(bpd_pkg::QDepth - 1)) ? '0 :
				            rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ----- sv/bpd_back.sv -----
// bpd_back: steps through the results of the head group into the output
// register, one per cycle unless the output stalls. Depends on bpd_pkg.
module bpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bpd_pkg::entry_t  head,
	input  logic             head_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_raw,
	output logic             out_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_raw_q;
	logic       out_last_q;
	logic       load;
	logic       is_last;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign is_last = (idx_q == head.last_idx);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.res_byte[idx_q];
			out_raw_q  <= head.res_raw[idx_q];
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_raw   = out_raw_q;
	assign out_last  = out_last_q;

endmodule

// ----- sv/byte_level_bpe_piece_decoder_top.sv -----
// Byte-level BPE piece decoder. Takes one byte of a vocabulary piece per request
// (piece_end marks the piece's last byte), groups the bytes into UTF-8 sequences by the
// length the lead byte announces, and maps each code point below 512 that is in the
// inverse byte-to-unicode table back to one raw byte (out_raw = 0); any other sequence
// passes its original bytes through (out_raw = 1). Continuation bits are not checked,
// a bad lead is a one-byte sequence, and a sequence cut short by the piece end is
// re-parsed with its lead standing alone. out_last marks the last result of the input
// request that finished a group; requests that only extend a sequence give no result.
// Rate: one input request per cycle while the group queue takes the held group, and
// one result per cycle unless the output stalls. The four-deep group queue absorbs
// bursts, so at a sustained one result per input byte, with out_ready held high, the
// input never stalls. A group's first result passes through the group register, the
// queue and the output register. Depends on bpd_pkg, bpd_front, bpd_queue, bpd_back.
module byte_level_bpe_piece_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       piece_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_raw,
	output logic       out_last
);

	// front -> queue
	logic                           push;
	bpd_pkg::entry_t                push_entry;
	logic                           q_ready;
	bpd_pkg::fstat_t                fstat;

	// queue -> back
	bpd_pkg::entry_t                head;
	logic                           head_valid;
	logic                           pop;
	logic [bpd_pkg::QCntW-1:0]      q_level;

	// Front: buffers the open sequence and classifies each finished group
	bpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.piece_end  (piece_end),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.fstat      (fstat)
	);

	// Decouples classification from result delivery
	bpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.level      (q_level)
	);

	// Back: hands out the group's results through the output register
	bpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_raw    (out_raw),
		.out_last   (out_last)
	);

`ifndef SYNTHESIS
	// A piece end always leaves the sequence buffer empty
	a_piece_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && piece_end |=> fstat.pend_cnt == 2'd0)
		else $error("sequence buffer not empty after piece end");

	// Queue occupancy never passes its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= bpd_pkg::QCntW'(bpd_pkg::QDepth))
		else $error("group queue overflow");

	// A held group waits while the queue is full
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.s1_valid && !q_ready |=> fstat.s1_valid)
		else $error("group dropped while queue full");
`endif

endmodule

// ----- verif/tb_byte_level_bpe_piece_decoder_top.sv -----
// Testbench for byte_level_bpe_piece_decoder_top: random and directed piece bytes, with a
// ledger class that predicts decoded bytes and checks each result as it leaves the block.
// Depends on bpd_pkg (group size) and the decoder RTL; reads no files.
`timescale 1ns / 1ps

module tb_byte_level_bpe_piece_decoder_top;

	// Random phase runs until this many input requests, directed ones included, are sent
	localparam int PieceBytesTarget = 480;

	// One expected result beat
	typedef struct {
		bit [7:0] data;
		bit       raw;
		bit       last;
	} decoded_beat_t;

	// Shapes of sequence the random generator builds
	typedef enum int {
		SEQ_ASCII,
		SEQ_TWO,
		SEQ_THREE,
		SEQ_FOUR,
		SEQ_NOISE
	} seq_kind_t;

	// Ledger: tracks the partial UTF-8 sequence like the block does and keeps the decoded
	// bytes still owed by it, oldest first.
	class decoded_byte_ledger;
		bit [7:0]      held[3];
		int            held_cnt;
		int            held_len;
		decoded_beat_t bytes_due[$];
		int            mismatches;

		function new();
			held_cnt   = 0;
			held_len   = 0;
			mismatches = 0;
		endfunction

		// Length a lead byte announces; anything not a valid lead stands alone
		function int lead_span(bit [7:0] b);
			if (b[7] == 1'b0)
				return 1;
			if ((b & 8'hE0) == 8'hC0)
				return 2;
			if ((b & 8'hF0) == 8'hE0)
				return 3;
			if ((b & 8'hF8) == 8'hF0)
				return 4;
			return 1;
		endfunction

		// Inverse byte-to-unicode lookup; returns 1 on a hit
		function bit unmap_cp(int unsigned cp, output bit [7:0] b);
			int unsigned idx;
			b = 8'd0;
			if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) ||
			    (cp >= 174 && cp <= 255)) begin
				b = 8'(cp);
				return 1'b1;
			end
			if (cp >= 256 && cp < 512) begin
				idx = cp - 256;
				if (idx < 33) begin
					b = 8'(idx);
					return 1'b1;
				end
				if (idx < 67) begin
					b = 8'(127 + idx - 33);
					return 1'b1;
				end
				if (idx == 67) begin
					b = 8'd173;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void push_beat(bit [7:0] d, bit r);
			decoded_beat_t t;
			t.data = d;
			t.raw  = r;
			t.last = 1'b0;
			bytes_due.push_back(t);
		endfunction

		// Decode a closed group; a lead that would overrun the group stands alone
		function void decode_group(bit [7:0] g[bpd_pkg::GrpBytes], int total);
			int          pos;
			int          n;
			int          k;
			int          j;
			int unsigned cp;
			bit [7:0]    m;
			pos = 0;
			k   = 0;
			while (pos < total) begin
				n = lead_span(g[pos]);
				if (pos + n > total)
					n = 1;
				case (n)
					1: cp = 32'(g[pos]);
					2: cp = (32'(g[pos] & 8'h1F) << 6) | 32'(g[pos+1] & 8'h3F);
					3: cp = (32'(g[pos] & 8'h0F) << 12) | (32'(g[pos+1] & 8'h3F) << 6) |
					        32'(g[pos+2] & 8'h3F);
					default: cp = (32'(g[pos] & 8'h07) << 18) |
					              (32'(g[pos+1] & 8'h3F) << 12) |
					              (32'(g[pos+2] & 8'h3F) << 6) | 32'(g[pos+3] & 8'h3F);
				endcase
				if (cp < 512 && unmap_cp(cp, m)) begin
					push_beat(m, 1'b0);
					k++;
				end else begin
					for (j = 0; j < n; j++) begin
						push_beat(g[pos+j], 1'b1);
						k++;
					end
				end
				pos += n;
			end
			if (k > 0)
				bytes_due[bytes_due.size()-1].last = 1'b1;
		endfunction

		// One accepted request
		function void note_piece_byte(bit [7:0] b, bit fin);
			bit [7:0] g[bpd_pkg::GrpBytes];
			int       i;
			int       total;
			int       span;
			for (i = 0; i < bpd_pkg::GrpBytes; i++)
				g[i] = 8'd0;
			for (i = 0; i < held_cnt; i++)
				g[i] = held[i];
			g[held_cnt] = b;
			total = held_cnt + 1;
			span  = (held_cnt == 0) ? lead_span(b) : held_len;
			if (fin || total >= span || total >= bpd_pkg::GrpBytes) begin
				held_cnt = 0;
				held_len = 0;
				decode_group(g, total);
			end else begin
				held[held_cnt] = b;
				held_cnt = total;
				held_len = span;
			end
		endfunction

		// One accepted result against the oldest expectation
		function void check_decoded(bit [7:0] d, bit r, bit l);
			decoded_beat_t t;
			if (bytes_due.size() == 0) begin
				$error("unexpected result: out_byte %h out_raw %0d out_last %0d", d, r, l);
				mismatches++;
				return;
			end
			t = bytes_due.pop_front();
			if (t.data !== d) begin
				$error("out_byte: expected %h, got %h", t.data, d);
				mismatches++;
			end
			if (t.raw !== r) begin
				$error("out_raw: expected %0d, got %0d", t.raw, r);
				mismatches++;
			end
			if (t.last !== l) begin
				$error("out_last: expected %0d, got %0d", t.last, l);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return bytes_due.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       piece_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_raw;
	logic       out_last;

	decoded_byte_ledger ledger;

	// Sender pacing
	int sent_count  = 0;
	int burst_left  = 0;
	bit steady_send = 1'b0;

	// Long receiver hold-off: main sets the request, receiver counts it out
	bit hold_req = 1'b0;

	byte_level_bpe_piece_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.piece_end (piece_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_raw   (out_raw),
		.out_last  (out_last)
	);

	always #10 clk = ~clk;

	// Both channels sampled at the rising edge. A request accepted on this edge cannot
	// produce a result on the same edge, so the two calls never depend on each other.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				ledger.note_piece_byte(in_byte, piece_end);
			if (out_valid && out_ready)
				ledger.check_decoded(out_byte, out_raw, out_last);
		end
	end

	// Drop valid; n sets the length of the idle stretch
	task automatic idle_input(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Offer one request and hold it until accepted. Bursts of random length with random
	// gaps between them, unless steady_send keeps the input saturated.
	task automatic send_byte(bit [7:0] b, bit fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!steady_send)
				idle_input($urandom_range(0, 6));
		end
		burst_left--;
		@(negedge clk);
		in_valid  <= 1'b1;
		in_byte   <= b;
		piece_end <= fin;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	// Stop sending until every owed result has come out
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// Continuation byte, now and then broken (continuation bits are never checked)
	function automatic bit [7:0] cont_byte(bit [5:0] v);
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom);
		return {2'b10, v};
	endfunction

	// One piece: a few sequences, mostly well formed, sometimes cut short, with the odd
	// stray piece end in the middle.
	task automatic send_random_piece();
		bit [7:0]  q[$];
		bit [20:0] cp;
		seq_kind_t kind;
		int        nseq;
		int        s;
		int        r;
		int        j;
		int        cut;
		bit        fin;
		nseq = $urandom_range(1, 3);
		for (s = 0; s < nseq; s++) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				kind = SEQ_ASCII;
			else if (r < 50)
				kind = SEQ_TWO;
			else if (r < 70)
				kind = SEQ_THREE;
			else if (r < 85)
				kind = SEQ_FOUR;
			else
				kind = SEQ_NOISE;
			case (kind)
				SEQ_ASCII: q.push_back(8'($urandom_range(0, 127)));
				SEQ_TWO: begin
					// mostly code points in the table's range, some overlong or high
					if ($urandom_range(0, 3) != 0)
						cp = 21'($urandom_range(128, 511));
					else
						cp = 21'($urandom_range(0, 2047));
					q.push_back({3'b110, cp[10:6]});
					q.push_back(cont_byte(cp[5:0]));
				end
				SEQ_THREE: begin
					// overlong forms can still land below 512
					if ($urandom_range(0, 2) == 0)
						cp = 21'($urandom_range(0, 511));
					else
						cp = 21'($urandom_range(0, 65535));
					q.push_back({4'b1110, cp[15:12]});
					q.push_back(cont_byte(cp[11:6]));
					q.push_back(cont_byte(cp[5:0]));
				end
				SEQ_FOUR: begin
					if ($urandom_range(0, 2) == 0)
						cp = 21'($urandom_range(0, 511));
					else
						cp = 21'($urandom);
					q.push_back({5'b11110, cp[20:18]});
					q.push_back(cont_byte(cp[17:12]));
					q.push_back(cont_byte(cp[11:6]));
					q.push_back(cont_byte(cp[5:0]));
				end
				default: begin
					repeat ($urandom_range(1, 3))
						q.push_back(8'($urandom));
				end
			endcase
		end
		// piece ends inside a sequence
		if (q.size() > 1 && $urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, q.size() - 1);
			repeat (cut)
				void'(q.pop_back());
		end
		for (j = 0; j < q.size(); j++) begin
			fin = (j == q.size() - 1) || ($urandom_range(0, 15) == 0);
			send_byte(q[j], fin);
		end
	endtask

	// Receiver: stall pattern periodically redrawn from four modes; a hold request forces
	// a long stretch of ready low so the group queue fills and in_ready drops.
	initial begin
		int rx_cycle;
		int rx_mode;
		int hold_left;
		rx_cycle  = 0;
		rx_mode   = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 48 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((rx_cycle % 7) < 4);
				endcase
			end
		end
	end

	// Main sequence
	initial begin
		bit hold_done;
		bit pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		ledger     = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_byte   <= 8'd0;
		piece_end <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: single-byte extremes, table edges, two-byte table entries,
		// overlong form, long raw sequences, a piece end cutting a sequence, bad lead.
		send_byte(8'h00, 1'b1);  // zero byte, no entry
		send_byte(8'hFF, 1'b1);
		send_byte(8'h20, 1'b1);  // just below the printable range
		send_byte(8'h21, 1'b1);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hAD, 1'b1);  // hole in the upper range
		send_byte(8'hAE, 1'b1);
		send_byte(8'hC4, 1'b0);  // U+0100 -> 0x00
		send_byte(8'h80, 1'b1);
		send_byte(8'hC5, 1'b0);  // U+0143 -> 0xAD
		send_byte(8'h83, 1'b1);
		send_byte(8'hC5, 1'b0);  // U+0144, past the table: raw pair
		send_byte(8'h84, 1'b1);
		send_byte(8'hC1, 1'b0);  // overlong 'a'
		send_byte(8'hA1, 1'b1);
		send_byte(8'hE0, 1'b0);  // three-byte zero: raw triple
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hF0, 1'b0);  // U+10000: four raw results from one request
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hE2, 1'b0);  // cut short: lead alone, then a stray continuation
		send_byte(8'h82, 1'b1);
		send_byte(8'hF8, 1'b1);  // bad lead stands alone
		wait_drain();

		while (sent_count < PieceBytesTarget) begin
			// long output hold-off while the input keeps pushing
			if (!hold_done && sent_count >= 150) begin
				hold_done   = 1'b1;
				hold_req    = 1'b1;
				steady_send = 1'b1;
			end else if (hold_done && sent_count >= 200 && sent_count < 210) begin
				steady_send = 1'b0;
			end else if (sent_count >= 210 && $urandom_range(0, 11) == 0) begin
				steady_send = !steady_send;
			end
			// one full pause until everything owed has come out
			if (!pause_done && sent_count >= 320) begin
				pause_done = 1'b1;
				wait_drain();
			end
			send_random_piece();
		end

		wait_drain();
		repeat (10) @(posedge clk);
		if (ledger.outstanding() != 0) begin
			$error("%0d expected results never arrived", ledger.outstanding());
			ledger.mismatches++;
		end
		if (ledger.mismatches == 0)
			$display("byte_level_bpe_piece_decoder_top verification clean");
		else
			$display("byte_level_bpe_piece_decoder_top verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("byte_level_bpe_piece_decoder_top verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/bpd_pkg.sv
sv/bpd_front.sv
sv/bpd_queue.sv
sv/bpd_back.sv
sv/byte_level_bpe_piece_decoder_top.sv
verif/tb_byte_level_bpe_piece_decoder_top.sv
